// File: rtl/fan_thermostat_button_controller_macros.svh
// Assertion macros for the checker file of the fan controller.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef FAN_THERMOSTAT_BUTTON_CONTROLLER_MACROS_SVH
`define FAN_THERMOSTAT_BUTTON_CONTROLLER_MACROS_SVH

// same-cycle implication
`define FTBC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ftbc_pkg.sv
// Package for the fan thermostat button controller: item codes, register
// indexes, reset values and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package ftbc_pkg;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_REMOTE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CMD_TOGGLE  = 2'd0,
        CMD_FAN_ON  = 2'd1,
        CMD_FAN_OFF = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_TEMP_ON      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEMP_OFF     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_CLICK = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_HALF   = 3'd4;

    localparam logic signed [10:0] TEMP_ON_RESET  = 11'sd300;
    localparam logic signed [10:0] TEMP_OFF_RESET = 11'sd280;
    localparam logic [15:0] DEBOUNCE_RESET     = 16'd50;
    localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd500;
    localparam logic [15:0] BLINK_HALF_RESET   = 16'd150;

    // blink sequence length in half periods
    localparam logic [2:0] BLINK_LIMIT_CLICK = 3'd6;
    localparam logic [2:0] BLINK_LIMIT_EVENT = 3'd4;

    typedef struct packed {
        logic signed [10:0] temp_on;
        logic signed [10:0] temp_off;
        logic [15:0]        debounce;
        logic [15:0]        double_click;
        logic [15:0]        blink_half;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic               button_level;
        logic signed [10:0] temperature;
        logic               sample_valid;
        t_cmd               command;
    } t_item;

    typedef struct packed {
        logic fan_on;
        logic auto_mode;
        logic backlight_on;
        logic blinking;
        logic sensor_error;
    } t_result;

endpackage

// File: rtl/ftbc_cfg_regs.sv
// Configuration register bank of the fan controller.
// Depends on ftbc_pkg for register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module ftbc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [ftbc_pkg::CFG_IDX_BITS-1:0] i_wr_index,
    input  logic [15:0]                       i_wr_data,
    output ftbc_pkg::t_cfg                    o_cfg
);

    ftbc_pkg::t_cfg r_cfg;
    ftbc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                ftbc_pkg::REG_TEMP_ON:      n_cfg.temp_on      = i_wr_data[10:0];
                ftbc_pkg::REG_TEMP_OFF:     n_cfg.temp_off     = i_wr_data[10:0];
                ftbc_pkg::REG_DEBOUNCE:     n_cfg.debounce     = i_wr_data;
                ftbc_pkg::REG_DOUBLE_CLICK: n_cfg.double_click = i_wr_data;
                ftbc_pkg::REG_BLINK_HALF:   n_cfg.blink_half   = i_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_on      <= ftbc_pkg::TEMP_ON_RESET;
            r_cfg.temp_off     <= ftbc_pkg::TEMP_OFF_RESET;
            r_cfg.debounce     <= ftbc_pkg::DEBOUNCE_RESET;
            r_cfg.double_click <= ftbc_pkg::DOUBLE_CLICK_RESET;
            r_cfg.blink_half   <= ftbc_pkg::BLINK_HALF_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/ftbc_core.sv
// Controller state and single-pass update logic: time counter, blink
// sequencer, click detection, thermostat and remote commands. Depends on ftbc_pkg.
`timescale 1ns / 1ps

module ftbc_core #(
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  ftbc_pkg::t_item   i_item,
    input  ftbc_pkg::t_cfg    i_cfg,
    output ftbc_pkg::t_result o_result
);

    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_now_p1, n_now_p1;
    logic [TIME_BITS-1:0] r_press_start, n_press_start;
    logic [TIME_BITS-1:0] r_last_click, n_last_click;
    logic [TIME_BITS-1:0] r_last_toggle, n_last_toggle;
    logic                 r_held, n_held;
    logic                 r_mode_auto, n_mode_auto;
    logic                 r_fan, n_fan;
    logic                 r_blink_active, n_blink_active;
    logic                 r_dark, n_dark;
    logic [2:0]           r_blink_done, n_blink_done;
    logic [2:0]           r_blink_limit, n_blink_limit;

    logic [TIME_BITS-1:0] el_toggle;
    logic [TIME_BITS-1:0] el_press;
    logic [TIME_BITS-1:0] el_click;
    logic [2:0]           done_inc;
    logic signed [10:0]   temp;
    logic signed [10:0]   thr_on;
    logic signed [10:0]   thr_off;
    logic                 err;

    // a tick sees the incremented time, held ahead in r_now_p1
    assign el_toggle = r_now_p1 - r_last_toggle;
    assign el_press  = r_now_p1 - r_press_start;
    assign el_click  = r_now_p1 - r_last_click;
    assign done_inc  = r_blink_done + 3'd1;
    assign temp      = i_item.temperature;
    assign thr_on    = i_cfg.temp_on;
    assign thr_off   = i_cfg.temp_off;

    always_comb begin
        n_now          = r_now;
        n_now_p1       = r_now_p1;
        n_press_start  = r_press_start;
        n_last_click   = r_last_click;
        n_last_toggle  = r_last_toggle;
        n_held         = r_held;
        n_mode_auto    = r_mode_auto;
        n_fan          = r_fan;
        n_blink_active = r_blink_active;
        n_dark         = r_dark;
        n_blink_done   = r_blink_done;
        n_blink_limit  = r_blink_limit;
        err            = 1'b0;
        case (i_item.kind)
            ftbc_pkg::KIND_TICK: begin
                n_now    = r_now_p1;
                n_now_p1 = r_now_p1 + TIME_BITS'(1);
                if (r_blink_active && el_toggle >= TIME_BITS'(i_cfg.blink_half)) begin
                    n_last_toggle = r_now_p1;
                    n_dark        = !r_dark;
                    n_blink_done  = done_inc;
                    if (done_inc >= r_blink_limit) begin
                        n_blink_active = 1'b0;
                    end
                end
                if (!i_item.button_level && !r_held) begin
                    n_press_start = r_now_p1;
                    n_held        = 1'b1;
                end
                if (i_item.button_level && r_held) begin
                    n_held = 1'b0;
                    if (el_press > TIME_BITS'(i_cfg.debounce)) begin
                        n_last_click = r_now_p1;
                        if (el_click < TIME_BITS'(i_cfg.double_click)) begin
                            n_mode_auto    = !r_mode_auto;
                            n_blink_active = 1'b1;
                            n_blink_limit  = ftbc_pkg::BLINK_LIMIT_CLICK;
                            n_blink_done   = 3'd0;
                            n_dark         = 1'b0;
                            n_last_toggle  = r_now_p1;
                        end else if (!r_mode_auto) begin
                            n_fan = !r_fan;
                        end
                    end
                end
            end
            ftbc_pkg::KIND_SAMPLE: begin
                if (!i_item.sample_valid) begin
                    err = 1'b1;
                end else if (r_mode_auto) begin
                    if (temp >= thr_on && !r_fan) begin
                        n_fan          = 1'b1;
                        n_blink_active = 1'b1;
                        n_blink_limit  = ftbc_pkg::BLINK_LIMIT_EVENT;
                        n_blink_done   = 3'd0;
                        n_dark         = 1'b0;
                        n_last_toggle  = r_now;
                    end else if (temp <= thr_off) begin
                        n_fan = 1'b0;
                    end
                end
            end
            ftbc_pkg::KIND_REMOTE: begin
                case (i_item.command)
                    ftbc_pkg::CMD_TOGGLE: begin
                        n_mode_auto    = !r_mode_auto;
                        n_blink_active = 1'b1;
                        n_blink_limit  = ftbc_pkg::BLINK_LIMIT_EVENT;
                        n_blink_done   = 3'd0;
                        n_dark         = 1'b0;
                        n_last_toggle  = r_now;
                    end
                    ftbc_pkg::CMD_FAN_ON: begin
                        if (!r_mode_auto) begin
                            n_fan = 1'b1;
                        end
                    end
                    ftbc_pkg::CMD_FAN_OFF: begin
                        if (!r_mode_auto) begin
                            n_fan = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.fan_on       = n_fan;
        o_result.auto_mode    = n_mode_auto;
        o_result.backlight_on = !(n_blink_active && n_dark);
        o_result.blinking     = n_blink_active;
        o_result.sensor_error = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now          <= '0;
            r_now_p1       <= TIME_BITS'(1);
            r_press_start  <= '0;
            r_last_click   <= '0;
            r_last_toggle  <= '0;
            r_held         <= 1'b0;
            r_mode_auto    <= 1'b1;
            r_fan          <= 1'b0;
            r_blink_active <= 1'b0;
            r_dark         <= 1'b0;
            r_blink_done   <= 3'd0;
            r_blink_limit  <= 3'd0;
        end else if (i_step) begin
            r_now          <= n_now;
            r_now_p1       <= n_now_p1;
            r_press_start  <= n_press_start;
            r_last_click   <= n_last_click;
            r_last_toggle  <= n_last_toggle;
            r_held         <= n_held;
            r_mode_auto    <= n_mode_auto;
            r_fan          <= n_fan;
            r_blink_active <= n_blink_active;
            r_dark         <= n_dark;
            r_blink_done   <= n_blink_done;
            r_blink_limit  <= n_blink_limit;
        end
    end

endmodule

// File: rtl/fan_thermostat_button_controller.sv
// Throughput: one item per cycle while the output is not stalled; input register,
// one update pass, result register. The output register frees as its result is
// taken, so input and output stall only together. Reset (synchronous, active
// low) clears both stages, restores register defaults and the controller state:
// auto mode, fan off, no blinking.
`timescale 1ns / 1ps

module fan_thermostat_button_controller #(
    parameter int TIME_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic                              i_button_level,
    input  logic signed [10:0]                i_temperature,
    input  logic                              i_sample_valid,
    input  logic [1:0]                        i_command,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_fan_on,
    output logic                              o_auto_mode,
    output logic                              o_backlight_on,
    output logic                              o_blinking,
    output logic                              o_sensor_error,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ftbc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    ftbc_pkg::t_item   r_in;
    logic              r_in_valid;
    ftbc_pkg::t_result r_out;
    logic              r_out_valid;
    ftbc_pkg::t_item   in_item;
    ftbc_pkg::t_result core_result;
    ftbc_pkg::t_cfg    cfg;
    logic              out_load;
    logic              advance;
    logic              in_accept;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_item.kind         = ftbc_pkg::t_kind'(i_kind);
        in_item.button_level = i_button_level;
        in_item.temperature  = i_temperature;
        in_item.sample_valid = i_sample_valid;
        in_item.command      = ftbc_pkg::t_cmd'(i_command);
    end

    ftbc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    ftbc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fan_on       = r_out.fan_on;
    assign o_auto_mode    = r_out.auto_mode;
    assign o_backlight_on = r_out.backlight_on;
    assign o_blinking     = r_out.blinking;
    assign o_sensor_error = r_out.sensor_error;

endmodule

// File: rtl/ftbc_checker.sv
// Port-level checker for the fan controller, bound to the top level.
// Depends on fan_thermostat_button_controller_macros.svh.
`timescale 1ns / 1ps
`include "fan_thermostat_button_controller_macros.svh"

module ftbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_fan_on,
    input logic o_auto_mode,
    input logic o_backlight_on,
    input logic o_blinking,
    input logic o_sensor_error
);

    `FTBC_ASSERT_IMPL(a_dark_only_blinking, o_out_valid && !o_backlight_on, o_blinking, "backlight dark outside a blink sequence")
    `FTBC_ASSERT_IMPL(a_empty_never_stalls, !o_out_valid, !o_in_stall, "input stalled with empty output")
    `FTBC_ASSERT_NEXT(a_item_reaches_output, (i_in_valid && !o_in_stall) ##1 !i_out_stall, o_out_valid, "accepted item did not reach the output")
    `FTBC_ASSERT_NEXT(a_stalled_result_holds, o_out_valid && i_out_stall, o_out_valid && $stable(o_fan_on) && $stable(o_auto_mode) && $stable(o_backlight_on) && $stable(o_blinking) && $stable(o_sensor_error), "stalled result changed")

endmodule

bind fan_thermostat_button_controller ftbc_checker u_ftbc_checker (.*);
